/* src/mmf_pkg.sv */
package mmf_pkg;

    // Defaults for the top-level parameters.
    localparam int MMF_MAX_DIM   = 16;
    localparam int MMF_FRAC_BITS = 16;

    // Fixed field widths of the stream and configuration ports.
    localparam int CFG_W     = 5;   // dimension register width
    localparam int CFG_IDX_W = 2;   // configuration register index width
    localparam int POS_W     = 4;   // row and column index width
    localparam int VAL_W     = 32;  // Q16.16 element width
    localparam int CMD_W     = 2;   // command code width
    localparam int IN_DATA_W = 40;  // row, column and value, exactly five whole bytes
    localparam int OUT_USER_W = 2;  // saturated and index_error

    // Command codes carried in the request tuser.
    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RD_C = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET_DIM = 5'd16;

    // Controller to datapath.
    typedef struct packed {
        logic accept;   // a request is taken this cycle
        logic start;    // clear the accumulator and the step counter
        logic issue;    // read one A/B pair at the current step
        logic finish;   // load the output register
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic is_read;     // the offered request is a result read
        logic rd_err;      // the offered read lies outside the result matrix
        logic issue_done;  // every step of the dot product has been issued
        logic pipe_empty;  // no product is still on its way to the accumulator
        logic out_free;    // the output register can take a new result
    } t_dp_stat;

endpackage

/* src/mmf_ctrl.sv */
module mmf_ctrl
    import mmf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_valid,
    output logic     o_s_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;

    assign o_s_ready = (r_state == S_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.accept = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_stat.is_read) begin
                    if (i_stat.rd_err) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (i_stat.issue_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* src/mmf_datapath.sv */
module mmf_datapath
    import mmf_pkg::*;
#(
    parameter int MAX_DIM   = MMF_MAX_DIM,
    parameter int FRAC_BITS = MMF_FRAC_BITS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_s_data,
    input  logic [CMD_W-1:0]      i_s_user,
    input  logic                  i_m_ready,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_m_valid,
    output logic [VAL_W-1:0]      o_m_data,
    output logic [OUT_USER_W-1:0] o_m_user
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    // Accumulator holds the exact sum of up to MAX_DIM full 64-bit products.
    localparam int ACC_W  = 2 * VAL_W + $clog2(MAX_DIM) + 1;
    // Effective dimensions saturate at MAX_DIM; above the register range no cap applies.
    localparam int DIM_CAP = (MAX_DIM < 31) ? MAX_DIM : 31;
    localparam logic [CFG_W-1:0]  CAP_C = CFG_W'(DIM_CAP);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_DIM);
    localparam logic [VAL_W-1:0]  SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0]  SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // Configuration registers and their effective values.
    logic [CFG_W-1:0] r_rows_a;
    logic [CFG_W-1:0] r_inner;
    logic [CFG_W-1:0] r_cols_b;
    logic [CFG_W-1:0] w_ra;
    logic [CFG_W-1:0] w_kd;
    logic [CFG_W-1:0] w_cb;

    // Request fields.
    logic [POS_W-1:0]        w_row;
    logic [POS_W-1:0]        w_col;
    logic signed [VAL_W-1:0] w_val;
    logic                    w_row_a_ok;
    logic                    w_col_a_ok;
    logic                    w_row_b_ok;
    logic                    w_col_b_ok;
    logic                    w_wr_a;
    logic                    w_wr_b;
    logic [ADDR_W-1:0]       w_wr_addr;

    // Read request context.
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_err;
    logic [CFG_W-1:0] r_k;
    logic [ADDR_W-1:0] w_rd_addr_a;
    logic [ADDR_W-1:0] w_rd_addr_b;

    // Element stores.
    logic signed [VAL_W-1:0] r_mem_a [DEPTH];
    logic signed [VAL_W-1:0] r_mem_b [DEPTH];

    // Multiply-accumulate pipeline.
    logic signed [VAL_W-1:0]   r_a_q;
    logic signed [VAL_W-1:0]   r_b_q;
    logic                      r_rd_v;
    logic signed [2*VAL_W-1:0] r_prod;
    logic                      r_prod_v;
    logic signed [ACC_W-1:0]   r_acc;

    // Rounding and saturation.
    logic signed [ACC_W-1:0] w_shift;
    logic                    w_fits;
    logic [VAL_W-1:0]        w_res;

    // Output register.
    logic                  r_out_v;
    logic [VAL_W-1:0]      r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= CFG_RESET_DIM;
            r_inner  <= CFG_RESET_DIM;
            r_cols_b <= CFG_RESET_DIM;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a <= i_cfg_data;
                CFG_INNER_DIM: r_inner  <= i_cfg_data;
                CFG_COLS_B:    r_cols_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ra = (r_rows_a > CAP_C) ? CAP_C : r_rows_a;
    assign w_kd = (r_inner  > CAP_C) ? CAP_C : r_inner;
    assign w_cb = (r_cols_b > CAP_C) ? CAP_C : r_cols_b;

    assign w_row = i_s_data[POS_W-1:0];
    assign w_col = i_s_data[2*POS_W-1:POS_W];
    assign w_val = i_s_data[2*POS_W+VAL_W-1:2*POS_W];

    assign w_row_a_ok = CFG_W'(w_row) < w_ra;
    assign w_col_a_ok = CFG_W'(w_col) < w_kd;
    assign w_row_b_ok = CFG_W'(w_row) < w_kd;
    assign w_col_b_ok = CFG_W'(w_col) < w_cb;

    assign w_wr_a = i_cmd.accept && (i_s_user == CMD_WR_A) && w_row_a_ok && w_col_a_ok;
    assign w_wr_b = i_cmd.accept && (i_s_user == CMD_WR_B) && w_row_b_ok && w_col_b_ok;
    assign w_wr_addr = ADDR_W'(w_row) * ROW_STRIDE + ADDR_W'(w_col);

    assign o_stat.is_read    = (i_s_user == CMD_RD_C);
    assign o_stat.rd_err     = !(w_row_a_ok && w_col_b_ok);
    assign o_stat.issue_done = (r_k >= w_kd);
    assign o_stat.pipe_empty = !r_rd_v && !r_prod_v;
    assign o_stat.out_free   = !r_out_v || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_row <= w_row;
            r_col <= w_col;
            r_err <= !(w_row_a_ok && w_col_b_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (i_cmd.start) begin
            r_k <= '0;
        end else if (i_cmd.issue) begin
            r_k <= r_k + 1'b1;
        end
    end

    // A walks along the row, B walks down the column.
    assign w_rd_addr_a = ADDR_W'(r_row) * ROW_STRIDE + ADDR_W'(r_k);
    assign w_rd_addr_b = ADDR_W'(r_k) * ROW_STRIDE + ADDR_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[w_wr_addr] <= w_val;
        end
        if (i_cmd.issue) begin
            r_a_q <= r_mem_a[w_rd_addr_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_b) begin
            r_mem_b[w_wr_addr] <= w_val;
        end
        if (i_cmd.issue) begin
            r_b_q <= r_mem_b[w_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v   <= 1'b0;
            r_prod_v <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.issue;
            r_prod_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_v) begin
            r_prod <= r_a_q * r_b_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_prod_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // Arithmetic shift floors the quotient; it fits when the bits above
    // the result's sign bit all copy that sign.
    assign w_shift = r_acc >>> FRAC_BITS;
    assign w_fits  = (&w_shift[ACC_W-1:VAL_W-1]) || !(|w_shift[ACC_W-1:VAL_W-1]);
    assign w_res   = w_fits ? w_shift[VAL_W-1:0]
                            : (w_shift[ACC_W-1] ? SAT_NEG : SAT_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_v <= 1'b1;
        end else if (i_m_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= r_err ? '0 : w_res;
            r_out_user <= {r_err, !r_err && !w_fits};
        end
    end

    assign o_m_valid = r_out_v;
    assign o_m_data  = r_out_data;
    assign o_m_user  = r_out_user;

endmodule

/* src/matrix_multiply_fixed_top.sv */
// Fixed-point matrix multiply C = A x B with signed Q16.16 elements, served one
// result element per read request. Each request carries a command in tuser:
// write an element of A, write an element of B, or read an element of C. Writes
// are dropped when the position lies outside the configured dimensions, and
// return nothing. A read inside the dimensions walks the dot product through a
// single shared multiply-accumulate unit, one A/B pair per cycle, and holds the
// block until its result is loaded; the exact sum is shifted right by FRAC_BITS
// with rounding toward minus infinity and clipped to 32 bits, with the saturated
// flag set on clipping. A read outside the dimensions returns zero with the
// index_error flag. Results sit in an output register, so the next request is
// taken while a finished result still waits for the sink. The user must write
// the dimension registers through the configuration port only while the block
// is idle; the block itself does not enforce this. Values above MAX_DIM act as
// MAX_DIM, and a zero makes that dimension empty. Elements of A and B must be
// written before a read uses them.
module matrix_multiply_fixed_top
    import mmf_pkg::*;
#(
    parameter int MAX_DIM   = MMF_MAX_DIM,
    parameter int FRAC_BITS = MMF_FRAC_BITS
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port: index 0 rows_a, 1 inner_dim, 2 cols_b.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // Request stream.
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // tdata from bit 0 up: row_index[3:0], col_index[7:4], element_value[39:8].
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: cmd[1:0].
    input  logic [CMD_W-1:0]      i_s_axis_tuser,
    // Result stream.
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // tdata: product_value[31:0].
    output logic [VAL_W-1:0]      o_m_axis_tdata,
    // tuser from bit 0 up: saturated[0], index_error[1].
    output logic [OUT_USER_W-1:0] o_m_axis_tuser
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // The controller sequences each request; it never touches payload.
    mmf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd)
    );

    // The datapath holds the dimension registers, both element stores, the
    // multiply-accumulate pipeline and the output register.
    mmf_datapath #(
        .MAX_DIM   (MAX_DIM),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_data    (i_s_axis_tdata),
        .i_s_user    (i_s_axis_tuser),
        .i_m_ready   (i_m_axis_tready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_m_valid   (o_m_axis_tvalid),
        .o_m_data    (o_m_axis_tdata),
        .o_m_user    (o_m_axis_tuser)
    );

    // The step counter must never be pushed past the dot product length.
    a_no_overissue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.issue |-> !w_stat.issue_done)
        else $error("step issued after the dot product was complete");

    // A result is only loaded when the output register can take it.
    a_finish_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> w_stat.out_free)
        else $error("result loaded over one not yet taken");

    // A new request is never accepted while products are still in flight.
    a_accept_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |-> w_stat.pipe_empty)
        else $error("request accepted with the accumulator pipeline busy");

    // Clearing the accumulator starts a fresh dot product with no stale steps.
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> !w_stat.issue_done || !o_s_axis_tready)
        else $error("dot product start left the controller idle");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top
    import mmf_pkg::*;
();

    // Command code that the block must ignore; the package names only the live ones.
    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

    // Idle wait after the last expected result, so that any request still in
    // flight can drain.
    localparam int SETTLE_CYCLES  = 32;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_COUNT    = 10;
    localparam int PHASE_REQUESTS = 110;

    localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
    localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

    // One result element as it leaves the block.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             sat;
        logic             err;
    } t_product;

    typedef enum logic {STEP_REQ, STEP_CFG} t_step_kind;

    // One row of the directed table: either a request or a new set of dimensions.
    typedef struct {
        t_step_kind       kind;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] val;
        bit               typed;
        t_product         want;
        logic [CFG_W-1:0] ra;
        logic [CFG_W-1:0] kd;
        logic [CFG_W-1:0] cb;
    } t_dir_step;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata = '0;
    logic [CMD_W-1:0]      i_s_axis_tuser = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [VAL_W-1:0]      o_m_axis_tdata;
    logic [OUT_USER_W-1:0] o_m_axis_tuser;

    matrix_multiply_fixed_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the block: dimension registers, both element stores, and a
    // flag per element telling whether it was ever written. Reads are only
    // issued once every element they touch carries that flag.
    logic [CFG_W-1:0] dim_rows = CFG_RESET_DIM;
    logic [CFG_W-1:0] dim_inner = CFG_RESET_DIM;
    logic [CFG_W-1:0] dim_cols = CFG_RESET_DIM;
    logic [VAL_W-1:0] a_store [MMF_MAX_DIM][MMF_MAX_DIM];
    logic [VAL_W-1:0] b_store [MMF_MAX_DIM][MMF_MAX_DIM];
    bit               a_known [MMF_MAX_DIM][MMF_MAX_DIM];
    bit               b_known [MMF_MAX_DIM][MMF_MAX_DIM];

    t_product  pending_products [$];
    t_dir_step directed_steps [$];

    int mismatch_count = 0;
    int served_requests = 0;
    int quiet_cycles = 0;
    int sink_stall_left = 0;
    bit src_eager = 1'b0;
    bit sink_eager = 1'b0;

    // Dimension values above MAX_DIM behave as MAX_DIM.
    function automatic int dim_eff(logic [CFG_W-1:0] v);
        return (v > MMF_MAX_DIM) ? MMF_MAX_DIM : int'(v);
    endfunction

    // Expected result element C[r][c] under the current dimensions: exact
    // wide accumulation, floor shift by the fraction width, clip to 32 bits.
    function automatic t_product predict_element(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
        logic signed [127:0] acc;
        logic signed [127:0] scaled;
        longint              term;
        t_product            res;
        acc = '0;
        res = '0;
        if (r >= dim_eff(dim_rows) || c >= dim_eff(dim_cols)) begin
            res.err = 1'b1;
            return res;
        end
        for (int k = 0; k < dim_eff(dim_inner); k++) begin
            term = longint'($signed(a_store[r][k])) * longint'($signed(b_store[k][c]));
            acc = acc + {{64{term[63]}}, term};
        end
        scaled = acc >>> MMF_FRAC_BITS;
        if (scaled > Q_MAX) begin
            res.value = 32'h7FFF_FFFF;
            res.sat = 1'b1;
        end else if (scaled < Q_MIN) begin
            res.value = 32'h8000_0000;
            res.sat = 1'b1;
        end else begin
            res.value = scaled[31:0];
        end
        return res;
    endfunction

    // Element values lean on the extremes and on sizes that keep sums in range.
    function automatic logic [VAL_W-1:0] rand_elem();
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return {{12{raw[19]}}, raw[19:0]};
            3, 4, 5: return {{7{raw[24]}}, raw[24:0]};
            default: return raw;
        endcase
    endfunction

    function automatic int gap_cycles(bit eager);
        int r;
        r = $urandom_range(0, 99);
        if (eager || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one request and, once it is accepted, updates the shadow state and
    // queues the expected result of a read. Entered and left at a falling edge;
    // tvalid is left high so that a back-to-back request keeps it up.
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [VAL_W-1:0] val,
                            input bit typed, input t_product want);
        int gap;
        gap = gap_cycles(src_eager);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {val, col, row};
        i_s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        case (cmd)
            CMD_WR_A: begin
                if (row < dim_eff(dim_rows) && col < dim_eff(dim_inner)) begin
                    a_store[row][col] = val;
                    a_known[row][col] = 1'b1;
                    served_requests++;
                end
            end
            CMD_WR_B: begin
                if (row < dim_eff(dim_inner) && col < dim_eff(dim_cols)) begin
                    b_store[row][col] = val;
                    b_known[row][col] = 1'b1;
                    served_requests++;
                end
            end
            CMD_RD_C: begin
                served_requests++;
                if (typed) pending_products.push_back(want);
                else pending_products.push_back(predict_element(row, col));
            end
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Drops the request stream, waits for every expected result and lets any
    // trailing work settle, so that the dimension registers may be written.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Writes all three dimension registers on consecutive cycles.
    task automatic set_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] kd,
                            input logic [CFG_W-1:0] cb);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_ROWS_A;
        i_cfg_data  <= ra;
        @(negedge i_clk);
        i_cfg_index <= CFG_INNER_DIM;
        i_cfg_data  <= kd;
        @(negedge i_clk);
        i_cfg_index <= CFG_COLS_B;
        i_cfg_data  <= cb;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        dim_rows  = ra;
        dim_inner = kd;
        dim_cols  = cb;
    endtask

    // Writes every element that a read of C[row][col] would use but that was
    // never written, so that no read ever touches undefined storage.
    task automatic fill_operands(input logic [POS_W-1:0] row, input logic [POS_W-1:0] col);
        for (int k = 0; k < dim_eff(dim_inner); k++) begin
            if (!a_known[row][k]) send_req(CMD_WR_A, row, 4'(k), rand_elem(), 1'b0, '0);
            if (!b_known[k][col]) send_req(CMD_WR_B, 4'(k), col, rand_elem(), 1'b0, '0);
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0: return 5'd0;
            1: return 5'd1;
            2: return 5'd16;
            3: return 5'($urandom_range(17, 31));
            4, 5, 6, 7: return 5'($urandom_range(2, 4));
            default: return 5'($urandom_range(1, 16));
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_pos(int limit);
        if (limit == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
        return 4'($urandom_range(0, limit - 1));
    endfunction

    function automatic void dir_req(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                                    logic [POS_W-1:0] col, logic [VAL_W-1:0] val);
        t_dir_step s;
        s = '{kind: STEP_REQ, cmd: cmd, row: row, col: col, val: val, typed: 1'b0,
              want: '0, ra: '0, kd: '0, cb: '0};
        directed_steps.push_back(s);
    endfunction

    // A read whose result is obvious from the operands.
    function automatic void dir_chk(logic [POS_W-1:0] row, logic [POS_W-1:0] col,
                                    logic [VAL_W-1:0] value, logic sat, logic err);
        t_dir_step s;
        s = '{kind: STEP_REQ, cmd: CMD_RD_C, row: row, col: col, val: '0, typed: 1'b1,
              want: '{value: value, sat: sat, err: err}, ra: '0, kd: '0, cb: '0};
        directed_steps.push_back(s);
    endfunction

    function automatic void dir_cfg(logic [CFG_W-1:0] ra, logic [CFG_W-1:0] kd,
                                    logic [CFG_W-1:0] cb);
        t_dir_step s;
        s = '{kind: STEP_CFG, cmd: '0, row: '0, col: '0, val: '0, typed: 1'b0,
              want: '0, ra: ra, kd: kd, cb: cb};
        directed_steps.push_back(s);
    endfunction

    // The sink stalls in runs of random length; in some phases it never stalls.
    always @(negedge i_clk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!sink_eager && $urandom_range(0, 3) == 0) begin
            sink_stall_left = gap_cycles(1'b0);
            i_m_axis_tready <= (sink_stall_left == 0);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Each accepted result is checked field by field against the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_product want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_products.size() == 0) begin
                $error("result with no read request pending: product_value %h", o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_products.pop_front();
                if (o_m_axis_tdata !== want.value) begin
                    $error("product_value mismatch: expected %h, got %h",
                           want.value, o_m_axis_tdata);
                    mismatch_count++;
                end
                if (o_m_axis_tuser[0] !== want.sat) begin
                    $error("saturated mismatch: expected %b, got %b",
                           want.sat, o_m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (o_m_axis_tuser[1] !== want.err) begin
                    $error("index_error mismatch: expected %b, got %b",
                           want.err, o_m_axis_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: any handshake or register write counts as progress.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("matrix_multiply_fixed_top verification failed");
            $finish;
        end
    end

    initial begin
        logic [CFG_W-1:0] ra;
        logic [CFG_W-1:0] kd;
        logic [CFG_W-1:0] cb;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        int               pick;
        int               phase_goal;

        // Directed table. With an inner dimension of one, every result is a
        // single product, so the extremes and the clipping can be read off.
        dir_cfg(5'd2, 5'd1, 5'd2);
        dir_req(CMD_WR_A, 4'd0, 4'd0, 32'h7FFF_FFFF);
        dir_req(CMD_WR_B, 4'd0, 4'd0, 32'h7FFF_FFFF);
        dir_chk(4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1, 1'b0);
        dir_req(CMD_WR_A, 4'd1, 4'd0, 32'h8000_0000);
        dir_chk(4'd1, 4'd0, 32'h8000_0000, 1'b1, 1'b0);
        dir_req(CMD_WR_B, 4'd0, 4'd1, 32'h8000_0000);
        dir_chk(4'd1, 4'd1, 32'h7FFF_FFFF, 1'b1, 1'b0);
        dir_chk(4'd0, 4'd1, 32'h8000_0000, 1'b1, 1'b0);
        // Smallest positive times minus one lsb: the shift rounds down to -1 lsb.
        dir_req(CMD_WR_A, 4'd0, 4'd0, 32'h0000_0001);
        dir_req(CMD_WR_B, 4'd0, 4'd0, 32'hFFFF_FFFF);
        dir_chk(4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        // Reads outside the result matrix.
        dir_chk(4'd2, 4'd0, 32'h0, 1'b0, 1'b1);
        dir_chk(4'd0, 4'd2, 32'h0, 1'b0, 1'b1);
        // Writes outside the dimensions and the reserved command change nothing.
        dir_req(CMD_WR_A, 4'd15, 4'd15, 32'hFFFF_FFFF);
        dir_req(CMD_WR_B, 4'd1, 4'd0, 32'h1234_5678);
        dir_req(CMD_RESERVED, 4'd15, 4'd15, 32'hFFFF_FFFF);
        dir_chk(4'd0, 4'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        dir_req(CMD_WR_A, 4'd0, 4'd0, 32'h0);
        dir_chk(4'd0, 4'd0, 32'h0, 1'b0, 1'b0);
        // An empty inner dimension gives an empty sum, not an error.
        dir_cfg(5'd2, 5'd0, 5'd2);
        dir_chk(4'd1, 4'd1, 32'h0, 1'b0, 1'b0);
        // An empty row dimension makes every read an error.
        dir_cfg(5'd0, 5'd1, 5'd2);
        dir_chk(4'd0, 4'd0, 32'h0, 1'b0, 1'b1);
        dir_chk(4'd15, 4'd15, 32'h0, 1'b0, 1'b1);
        // Oversized registers act as the full size.
        dir_cfg(5'd31, 5'd1, 5'd31);
        dir_req(CMD_WR_A, 4'd15, 4'd0, 32'h0001_0000);
        dir_req(CMD_WR_B, 4'd0, 4'd15, 32'h0002_0000);
        dir_req(CMD_RD_C, 4'd15, 4'd15, 32'h0);

        // Reset is released at a falling edge.
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_CFG) begin
                set_dims(directed_steps[i].ra, directed_steps[i].kd, directed_steps[i].cb);
            end else begin
                send_req(directed_steps[i].cmd, directed_steps[i].row, directed_steps[i].col,
                         directed_steps[i].val, directed_steps[i].typed,
                         directed_steps[i].want);
            end
        end

        // Random phases, each with its own dimensions and idling style. Reads are
        // the most frequent pick and are preceded by whatever writes their operands
        // still need; the rest are in-range writes, stray writes and reserved requests.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: begin ra = 5'd1; kd = 5'd1; cb = 5'd1; end
                1: begin ra = 5'd16; kd = 5'd16; cb = 5'd16; end
                2: begin ra = 5'd31; kd = 5'd17; cb = 5'd31; end
                default: begin ra = pick_dim(); kd = pick_dim(); cb = pick_dim(); end
            endcase
            set_dims(ra, kd, cb);
            src_eager  = ($urandom_range(0, 3) == 0);
            sink_eager = ($urandom_range(0, 3) == 0);
            phase_goal = served_requests + PHASE_REQUESTS;
            while (served_requests < phase_goal) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    row = pick_pos(dim_eff(dim_rows));
                    col = pick_pos(dim_eff(dim_cols));
                    if (row < dim_eff(dim_rows) && col < dim_eff(dim_cols))
                        fill_operands(row, col);
                    send_req(CMD_RD_C, row, col, rand_elem(), 1'b0, '0);
                end else if (pick < 65) begin
                    send_req(CMD_WR_A, pick_pos(dim_eff(dim_rows)), pick_pos(dim_eff(dim_inner)),
                             rand_elem(), 1'b0, '0);
                end else if (pick < 85) begin
                    send_req(CMD_WR_B, pick_pos(dim_eff(dim_inner)), pick_pos(dim_eff(dim_cols)),
                             rand_elem(), 1'b0, '0);
                end else if (pick < 95) begin
                    send_req($urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A,
                             4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                             rand_elem(), 1'b0, '0);
                end else begin
                    send_req(CMD_RESERVED, 4'($urandom_range(0, 15)),
                             4'($urandom_range(0, 15)), $urandom, 1'b0, '0);
                    // Reserved requests never count toward a phase, so make
                    // sure a phase of nothing but dead requests still ends.
                    if (dim_eff(dim_rows) == 0 && dim_eff(dim_inner) == 0) served_requests++;
                end
            end
        end

        // Drain: every read must be answered, then nothing more may appear.
        wait_idle();
        if (pending_products.size() != 0) begin
            $error("%0d expected results never arrived", pending_products.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("matrix_multiply_fixed_top verification clean");
        end else begin
            $display("matrix_multiply_fixed_top verification failed");
        end
        $finish;
    end

endmodule
